>>> design/grid_strip_index_generator_defines.svh
// assertion macros for the strip index generator
// both expect clk and rst_n in the scope where they are used
`ifndef GRID_STRIP_INDEX_GENERATOR_DEFINES_SVH
`define GRID_STRIP_INDEX_GENERATOR_DEFINES_SVH

// same-cycle implication
`define GSIG_ASSERT_SAME(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("gsig same-cycle check failed");

// next-cycle implication
`define GSIG_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("gsig next-cycle check failed");

`endif

>>> design/gsig_pkg.sv
package gsig_pkg;

  localparam int INDEX_W    = 23;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 9;
  localparam int DIM_W      = 9;
  localparam int ACROSS_W   = 7;

  // descriptor fields hold row, row + 1 and column offsets (all below 512)
  localparam int DESC_ROW_W = 9;
  localparam int DESC_OFF_W = 9;
  // compare width covering every parameter choice
  localparam int CMP_W      = 13;

  localparam int PROD_W = 2 * DIM_W;
  localparam int WLC_W  = PROD_W + ACROSS_W;
  localparam int WLCN_W = PROD_W + ACROSS_W + 1;
  localparam int SUM_W  = WLCN_W;

  localparam int MID_DEPTH = 2;
  localparam int OUT_DEPTH = 2;

  localparam logic [CFG_IDX_W-1:0] CFG_GRID_WIDTH     = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_GRID_LENGTH    = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_PATCHES_ACROSS = 2'd2;

  localparam logic [DIM_W-1:0]    RST_GRID_WIDTH     = 9'd16;
  localparam logic [DIM_W-1:0]    RST_GRID_LENGTH    = 9'd16;
  localparam logic [ACROSS_W-1:0] RST_PATCHES_ACROSS = 7'd1;

  localparam logic KIND_START = 1'b0;
  localparam logic KIND_EMIT  = 1'b1;

  typedef struct packed {
    logic kind;
    logic neighbour_above;
    logic neighbour_right;
  } gsig_in_t;

  typedef struct packed {
    logic [INDEX_W-1:0] vertex_index;
    logic               last_in_group;
  } gsig_out_t;

  // effective (clamped) configuration
  typedef struct packed {
    logic [DIM_W-1:0]    width;
    logic [DIM_W-1:0]    length;
    logic [ACROSS_W-1:0] across;
  } gsig_cfg_t;

  typedef enum logic [2:0] {
    PH_PAIR_CUR,
    PH_PAIR_ABOVE,
    PH_JOIN,
    PH_NB_LEAD,
    PH_REV_CUR,
    PH_REV_ABOVE,
    PH_REV_JOIN
  } gsig_phase_t;

  typedef enum logic [1:0] {
    BASE_GRID,
    BASE_NEIGH,
    BASE_TOP,
    BASE_TOP_NEIGH
  } gsig_base_t;

  // work item from front to back: index = base + mrow * width + off (base + off for the top bases)
  typedef struct packed {
    logic [DESC_ROW_W-1:0] mrow;
    logic [DESC_OFF_W-1:0] off;
    gsig_base_t            base;
    logic                  last;
  } gsig_desc_t;

  typedef struct packed {
    logic active;
    logic above;
    logic right;
  } gsig_front_stat_t;

endpackage

>>> design/gsig_fifo.sv
module gsig_fifo import gsig_pkg::*; #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             wr_en,
  input  logic [WIDTH-1:0] wr_data,
  output logic             full,
  input  logic             rd_en,
  output logic [WIDTH-1:0] rd_data,
  output logic             empty
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] slot_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic             wr_ok;
  logic             rd_ok;

  assign full    = (count_r == CNT_W'(DEPTH));
  assign empty   = (count_r == '0);
  assign wr_ok   = wr_en && !full;
  assign rd_ok   = rd_en && !empty;
  assign rd_data = slot_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (wr_ok) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + PTR_W'(1);
    end
    if (rd_ok) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + PTR_W'(1);
    end
    if (wr_ok && !rd_ok) begin
      count_nxt = count_r + CNT_W'(1);
    end else if (rd_ok && !wr_ok) begin
      count_nxt = count_r - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_ok) begin
      slot_r[wr_ptr_r] <= wr_data;
    end
  end

endmodule

>>> design/gsig_front.sv
module gsig_front import gsig_pkg::*; #(
  parameter int MAX_WIDTH  = 256,
  parameter int MAX_LENGTH = 256
) (
  input  logic             clk,
  input  logic             rst_n,
  input  gsig_cfg_t        cfg,
  input  logic             take,
  input  gsig_in_t         item,
  output logic             desc_push,
  output gsig_desc_t       desc,
  output gsig_front_stat_t stat
);

  localparam int RW = $clog2(MAX_LENGTH);
  localparam int CW = ($clog2(MAX_WIDTH) > 2) ? $clog2(MAX_WIDTH) : 2;

  logic [RW-1:0] row_r, row_nxt;
  logic [CW-1:0] col_r, col_nxt;
  gsig_phase_t   phase_r, phase_nxt;
  logic          above_r, above_nxt;
  logic          right_r, right_nxt;
  logic          active_r, active_nxt;

  logic [CMP_W-1:0] row_x, col_x, w_x, l_x, row_up_x, rows_total_x;
  logic             not_last, on_top, more_rows;
  logic [CW-1:0]    last_col;
  logic [RW-1:0]    row_next;
  logic [DESC_ROW_W-1:0] mrow_cur, mrow_up;
  logic [DESC_OFF_W-1:0] col_off, wm1_off;
  gsig_desc_t       d_cur, d_above_col, d_above_wm1, d_above_0, d_nb;

  assign row_x        = CMP_W'(row_r);
  assign col_x        = CMP_W'(col_r);
  assign w_x          = CMP_W'(cfg.width);
  assign l_x          = CMP_W'(cfg.length);
  assign row_up_x     = row_x + CMP_W'(1);
  assign rows_total_x = l_x - CMP_W'(1) + CMP_W'(above_r);
  assign not_last     = row_up_x < l_x;
  assign more_rows    = row_up_x < rows_total_x;
  assign on_top       = above_r && (row_x == l_x - CMP_W'(1));
  assign last_col     = CW'(w_x - CMP_W'(1));
  assign row_next     = row_up_x[RW-1:0];

  assign mrow_cur = row_x[DESC_ROW_W-1:0];
  assign mrow_up  = row_up_x[DESC_ROW_W-1:0];
  assign col_off  = col_x[DESC_OFF_W-1:0];
  assign wm1_off  = DESC_OFF_W'(w_x - CMP_W'(1));

  // address shapes; last is filled in below
  assign d_cur       = '{mrow: mrow_cur, off: col_off, base: BASE_GRID, last: 1'b0};
  assign d_above_col = on_top
                     ? gsig_desc_t'{mrow: mrow_cur, off: col_off, base: BASE_TOP, last: 1'b0}
                     : gsig_desc_t'{mrow: mrow_up, off: col_off, base: BASE_GRID, last: 1'b0};
  assign d_above_wm1 = on_top
                     ? gsig_desc_t'{mrow: mrow_cur, off: wm1_off, base: BASE_TOP, last: 1'b0}
                     : gsig_desc_t'{mrow: mrow_up, off: wm1_off, base: BASE_GRID, last: 1'b0};
  assign d_above_0   = on_top
                     ? gsig_desc_t'{mrow: mrow_cur, off: '0, base: BASE_TOP, last: 1'b0}
                     : gsig_desc_t'{mrow: mrow_up, off: '0, base: BASE_GRID, last: 1'b0};

  // neighbour row on the first index, its above row otherwise
  always_comb begin
    if (col_r == '0) begin
      d_nb = '{mrow: mrow_cur, off: '0, base: BASE_NEIGH, last: 1'b0};
    end else if (on_top) begin
      d_nb = '{mrow: mrow_cur, off: '0, base: BASE_TOP_NEIGH, last: 1'b0};
    end else begin
      d_nb = '{mrow: mrow_up, off: '0, base: BASE_NEIGH, last: 1'b0};
    end
  end

  always_comb begin
    logic do_end;
    do_end     = 1'b0;
    row_nxt    = row_r;
    col_nxt    = col_r;
    phase_nxt  = phase_r;
    above_nxt  = above_r;
    right_nxt  = right_r;
    active_nxt = active_r;
    desc_push  = 1'b0;
    desc       = d_cur;
    if (take) begin
      if (item.kind == KIND_START) begin
        above_nxt  = item.neighbour_above;
        right_nxt  = item.neighbour_right;
        active_nxt = 1'b1;
        row_nxt    = '0;
        col_nxt    = '0;
        phase_nxt  = PH_PAIR_CUR;
      end else if (active_r) begin
        desc_push = 1'b1;
        unique case (phase_r)
          PH_PAIR_CUR: begin
            desc      = d_cur;
            phase_nxt = PH_PAIR_ABOVE;
          end
          PH_PAIR_ABOVE: begin
            desc = d_above_col;
            if (col_x + CMP_W'(1) < w_x) begin
              phase_nxt = PH_PAIR_CUR;
              col_nxt   = col_r + CW'(1);
            end else if (right_r || not_last) begin
              phase_nxt = PH_JOIN;
              col_nxt   = '0;
            end else begin
              do_end = 1'b1;
            end
          end
          PH_JOIN: begin
            desc = right_r ? d_nb : d_above_wm1;
            if (right_r && (col_x < CMP_W'(2))) begin
              col_nxt = col_r + CW'(1);
            end else begin
              do_end = 1'b1;
            end
          end
          PH_NB_LEAD: begin
            desc = d_nb;
            if (col_x < CMP_W'(1)) begin
              col_nxt = col_r + CW'(1);
            end else begin
              phase_nxt = PH_REV_CUR;
              col_nxt   = last_col;
            end
          end
          PH_REV_CUR: begin
            desc      = d_cur;
            phase_nxt = PH_REV_ABOVE;
          end
          PH_REV_ABOVE: begin
            desc = d_above_col;
            if (col_r != '0) begin
              phase_nxt = PH_REV_CUR;
              col_nxt   = col_r - CW'(1);
            end else if (not_last) begin
              phase_nxt = PH_REV_JOIN;
            end else begin
              do_end = 1'b1;
            end
          end
          PH_REV_JOIN: begin
            desc   = d_above_0;
            do_end = 1'b1;
          end
          default: begin
            desc   = '{mrow: '0, off: '0, base: BASE_GRID, last: 1'b0};
            do_end = 1'b1;
          end
        endcase
        if (do_end) begin
          if (more_rows) begin
            row_nxt = row_next;
            // even rows run forward, odd rows backward
            if (!row_next[0]) begin
              phase_nxt = PH_PAIR_CUR;
              col_nxt   = '0;
            end else if (right_r) begin
              phase_nxt = PH_NB_LEAD;
              col_nxt   = '0;
            end else begin
              phase_nxt = PH_REV_CUR;
              col_nxt   = last_col;
            end
          end else begin
            active_nxt = 1'b0;
            desc.last  = 1'b1;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_r    <= '0;
      col_r    <= '0;
      phase_r  <= PH_PAIR_CUR;
      above_r  <= 1'b0;
      right_r  <= 1'b0;
      active_r <= 1'b0;
    end else begin
      row_r    <= row_nxt;
      col_r    <= col_nxt;
      phase_r  <= phase_nxt;
      above_r  <= above_nxt;
      right_r  <= right_nxt;
      active_r <= active_nxt;
    end
  end

  assign stat = '{active: active_r, above: above_r, right: right_r};

endmodule

>>> design/gsig_back.sv
module gsig_back import gsig_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  gsig_cfg_t  cfg,
  input  logic       q_empty,
  output logic       q_pop,
  input  gsig_desc_t q_desc,
  output logic       out_empty,
  input  logic       out_pop,
  output gsig_out_t  out_item
);

  // patch-size products, refreshed every cycle
  logic [PROD_W-1:0] wl_r;
  logic [WLC_W-1:0]  wlc_r;
  logic [WLCN_W-1:0] wlcn_r;

  logic              a_valid_r;
  logic [PROD_W-1:0] a_prod_r;
  logic [DESC_OFF_W-1:0] a_off_r;
  gsig_base_t        a_base_r;
  logic              a_last_r;

  logic              b_valid_r;
  gsig_out_t         b_item_r;

  logic [SUM_W-1:0]  sum;
  logic              ofifo_full;
  logic              adv;
  logic              ofifo_wr;

  assign adv      = !b_valid_r || !ofifo_full;
  assign q_pop    = adv && !q_empty;
  assign ofifo_wr = b_valid_r && !ofifo_full;

  always_ff @(posedge clk) begin
    wl_r   <= PROD_W'(cfg.width) * PROD_W'(cfg.length);
    wlc_r  <= WLC_W'(wl_r) * WLC_W'(cfg.across);
    wlcn_r <= WLCN_W'(wl_r) * (WLCN_W'(cfg.across) + WLCN_W'(1));
  end

  always_comb begin
    unique case (a_base_r)
      BASE_GRID:      sum = SUM_W'(a_prod_r) + SUM_W'(a_off_r);
      BASE_NEIGH:     sum = SUM_W'(wl_r) + SUM_W'(a_prod_r) + SUM_W'(a_off_r);
      BASE_TOP:       sum = SUM_W'(wlc_r) + SUM_W'(a_off_r);
      BASE_TOP_NEIGH: sum = SUM_W'(wlcn_r) + SUM_W'(a_off_r);
      default:        sum = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_valid_r <= 1'b0;
      b_valid_r <= 1'b0;
    end else if (adv) begin
      a_valid_r <= !q_empty;
      b_valid_r <= a_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      a_prod_r <= PROD_W'(q_desc.mrow) * PROD_W'(cfg.width);
      a_off_r  <= q_desc.off;
      a_base_r <= q_desc.base;
      a_last_r <= q_desc.last;
      b_item_r <= '{vertex_index: sum[INDEX_W-1:0], last_in_group: a_last_r};
    end
  end

  gsig_fifo #(
    .WIDTH ($bits(gsig_out_t)),
    .DEPTH (OUT_DEPTH)
  ) u_out_q (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (ofifo_wr),
    .wr_data (b_item_r),
    .full    (ofifo_full),
    .rd_en   (out_pop),
    .rd_data (out_item),
    .empty   (out_empty)
  );

endmodule

>>> design/grid_strip_index_generator.sv
// channel   ports                                   moves on
// in        in_push, in_full, in_item               in_push & !in_full
// out       out_empty, out_pop, out_item            out_pop & !out_empty
// cfg       cfg_valid, cfg_ready, cfg_index, cfg_data  cfg_valid & cfg_ready
//
// one request per cycle while in_full is low; an emit request's index reaches out_item
// through the descriptor queue, the multiply stage and the add stage into the result queue
// the front sequencer's row/column/phase update is the one-cycle loop
// reset clears control state only, no clearing pass; cfg_ready is always high
// stalls on out back up through the result queue, the back pipeline and the
// descriptor queue before in_full rises
`include "grid_strip_index_generator_defines.svh"

module grid_strip_index_generator import gsig_pkg::*; #(
  parameter int MAX_WIDTH          = 256,
  parameter int MAX_LENGTH         = 256,
  parameter int MAX_PATCHES_ACROSS = 64
) (
  input  logic                  clk,
  input  logic                  rst_n,
  // request side
  input  logic                  in_push,
  output logic                  in_full,
  input  gsig_in_t              in_item,
  // result side
  output logic                  out_empty,
  input  logic                  out_pop,
  output gsig_out_t             out_item,
  // register writes
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  logic [DIM_W-1:0]    grid_width_r;
  logic [DIM_W-1:0]    grid_length_r;
  logic [ACROSS_W-1:0] patches_across_r;

  gsig_cfg_t        cfg_eff;
  gsig_front_stat_t front_stat;
  gsig_desc_t       mid_desc;
  gsig_desc_t       back_desc;
  logic             in_acc;
  logic             mid_push;
  logic             mid_full;
  logic             mid_empty;
  logic             mid_pop;
  logic             emit_take;
  logic             start_take;
  logic [1:0]       start_flags;

  assign cfg_ready = 1'b1;
  assign in_acc    = in_push && !in_full;
  assign in_full   = mid_full;

  // register file, writes to unused indexes are dropped
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      grid_width_r     <= RST_GRID_WIDTH;
      grid_length_r    <= RST_GRID_LENGTH;
      patches_across_r <= RST_PATCHES_ACROSS;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_GRID_WIDTH:     grid_width_r     <= cfg_data[DIM_W-1:0];
        CFG_GRID_LENGTH:    grid_length_r    <= cfg_data[DIM_W-1:0];
        CFG_PATCHES_ACROSS: patches_across_r <= cfg_data[ACROSS_W-1:0];
        default: ;
      endcase
    end
  end

  // clamp to the supported range, read live by both halves
  always_comb begin
    if (grid_width_r < DIM_W'(2)) begin
      cfg_eff.width = DIM_W'(2);
    end else if (int'(grid_width_r) > MAX_WIDTH) begin
      cfg_eff.width = DIM_W'(MAX_WIDTH);
    end else begin
      cfg_eff.width = grid_width_r;
    end
    if (grid_length_r < DIM_W'(2)) begin
      cfg_eff.length = DIM_W'(2);
    end else if (int'(grid_length_r) > MAX_LENGTH) begin
      cfg_eff.length = DIM_W'(MAX_LENGTH);
    end else begin
      cfg_eff.length = grid_length_r;
    end
    if (patches_across_r < ACROSS_W'(1)) begin
      cfg_eff.across = ACROSS_W'(1);
    end else if (int'(patches_across_r) > MAX_PATCHES_ACROSS) begin
      cfg_eff.across = ACROSS_W'(MAX_PATCHES_ACROSS);
    end else begin
      cfg_eff.across = patches_across_r;
    end
  end

  // front: takes every request, walks the strip, queues one descriptor per index
  gsig_front #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_LENGTH (MAX_LENGTH)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_eff),
    .take      (in_acc),
    .item      (in_item),
    .desc_push (mid_push),
    .desc      (mid_desc),
    .stat      (front_stat)
  );

  // short queue decoupling the sequencer from the address datapath
  gsig_fifo #(
    .WIDTH ($bits(gsig_desc_t)),
    .DEPTH (MID_DEPTH)
  ) u_mid_q (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (mid_push),
    .wr_data (mid_desc),
    .full    (mid_full),
    .rd_en   (mid_pop),
    .rd_data (back_desc),
    .empty   (mid_empty)
  );

  // back: multiply, add base, hand over through the result queue
  gsig_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_eff),
    .q_empty   (mid_empty),
    .q_pop     (mid_pop),
    .q_desc    (back_desc),
    .out_empty (out_empty),
    .out_pop   (out_pop),
    .out_item  (out_item)
  );

  // request kinds as taken this cycle
  assign emit_take   = in_acc && (in_item.kind == KIND_EMIT);
  assign start_take  = in_acc && (in_item.kind == KIND_START);
  assign start_flags = {in_item.neighbour_above, in_item.neighbour_right};

  // descriptors only come from emit requests during a running group
  `GSIG_ASSERT_SAME(a_push_from_emit, mid_push, emit_take && front_stat.active)

  // a start request opens a group with its flags
  `GSIG_ASSERT_NEXT(a_start_latches, start_take, front_stat == {1'b1, $past(start_flags)})

  // the marked index closes the group
  `GSIG_ASSERT_NEXT(a_last_closes, mid_push && mid_desc.last, !front_stat.active)

endmodule

>>> test/grid_strip_index_generator_test.sv
module grid_strip_index_generator_test;
  import gsig_pkg::*;

  // block sizes, passed to the instance so the predictor clamps the same way
  localparam int MAX_WIDTH          = 256;
  localparam int MAX_LENGTH         = 256;
  localparam int MAX_PATCHES_ACROSS = 64;

  // register index that decodes to nothing
  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED_INDEX = 2'd3;

  // cycles to let the pipeline settle once no index is outstanding
  localparam int SETTLE_CYCLES = 12;
  // hard stop, far above the slowest correct run
  localparam int LIMIT_CYCLES  = 200000;
  // requests per idling mode in the random part
  localparam int RANDOM_ITEMS  = 400;
  // cap on printed mismatch lines
  localparam int PRINT_LIMIT   = 40;

  logic                  clk       = 1'b0;
  logic                  rst_n     = 1'b0;
  logic                  in_push   = 1'b0;
  logic                  in_full;
  gsig_in_t              in_item   = '0;
  logic                  out_empty;
  logic                  out_pop   = 1'b0;
  gsig_out_t             out_item;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data  = '0;

  grid_strip_index_generator #(
    .MAX_WIDTH         (MAX_WIDTH),
    .MAX_LENGTH        (MAX_LENGTH),
    .MAX_PATCHES_ACROSS(MAX_PATCHES_ACROSS)
  ) dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_push  (in_push),
    .in_full  (in_full),
    .in_item  (in_item),
    .out_empty(out_empty),
    .out_pop  (out_pop),
    .out_item (out_item),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data)
  );

  always #5 clk = ~clk;

  // idle chances in percent, changed between test phases
  int send_idle_pct = 29;
  int recv_idle_pct = 45;

  int cycle_count    = 0;
  int mismatch_count = 0;
  int items_sent     = 0;

  // indices still owed by the block, oldest first
  gsig_out_t expected_indices[$];

  // ---------------------------------------------------------------------
  // strip predictor: raw register copies plus the sequencer state
  // ---------------------------------------------------------------------
  logic [DIM_W-1:0]    width_reg  = RST_GRID_WIDTH;
  logic [DIM_W-1:0]    length_reg = RST_GRID_LENGTH;
  logic [ACROSS_W-1:0] across_reg = RST_PATCHES_ACROSS;

  int unsigned strip_row    = 0;
  int unsigned strip_col    = 0;
  gsig_phase_t strip_phase  = PH_PAIR_CUR;
  bit          flag_above   = 1'b0;
  bit          flag_right   = 1'b0;
  bit          strip_active = 1'b0;

  function automatic longint unsigned clamp_reg(longint unsigned v, longint unsigned lo,
                                                longint unsigned hi);
    if (v < lo) return lo;
    if (v > hi) return hi;
    return v;
  endfunction

  // even rows sweep right, odd rows sweep left (after the neighbour lead-in)
  function automatic void enter_row(longint unsigned w);
    if (strip_row % 2 == 0) begin
      strip_phase = PH_PAIR_CUR;
      strip_col   = 0;
    end else if (flag_right) begin
      strip_phase = PH_NB_LEAD;
      strip_col   = 0;
    end else begin
      strip_phase = PH_REV_CUR;
      strip_col   = 32'(w - 1);
    end
  endfunction

  // step to the next row; returns 1 when the group is finished
  function automatic bit end_row(longint unsigned w, longint unsigned l);
    longint unsigned rows_total;
    rows_total = l - 1 + (flag_above ? 1 : 0);
    if (strip_row + 1 < rows_total) begin
      strip_row++;
      enter_row(w);
      return 1'b0;
    end
    strip_active = 1'b0;
    return 1'b1;
  endfunction

  // applies one request; returns 1 and the index when it yields one
  function automatic bit next_strip_index(input gsig_in_t req, output gsig_out_t res);
    longint unsigned w, l, c, cur, abv, nbr, nba, v;
    bit top, not_last, done;
    w    = clamp_reg(width_reg, 2, MAX_WIDTH);
    l    = clamp_reg(length_reg, 2, MAX_LENGTH);
    c    = clamp_reg(across_reg, 1, MAX_PATCHES_ACROSS);
    res  = '0;
    done = 1'b0;
    if (req.kind == KIND_START) begin
      flag_above   = req.neighbour_above;
      flag_right   = req.neighbour_right;
      strip_active = 1'b1;
      strip_row    = 0;
      enter_row(w);
      return 1'b0;
    end
    if (!strip_active) return 1'b0;

    // row bases; the last row of an above-stitched group points into the patch above
    top = flag_above && (strip_row == l - 1);
    cur = strip_row * w;
    abv = top ? w * l * c : (strip_row + 1) * w;
    nbr = w * l + w * strip_row;
    nba = top ? w * l * (c + 1) : nbr + w;

    case (strip_phase)
      PH_PAIR_CUR:   v = cur + strip_col;
      PH_PAIR_ABOVE: v = abv + strip_col;
      PH_JOIN:       v = flag_right ? (strip_col == 0 ? nbr : nba) : abv + (w - 1);
      PH_NB_LEAD:    v = strip_col == 0 ? nbr : nba;
      PH_REV_CUR:    v = cur + strip_col;
      PH_REV_ABOVE:  v = abv + strip_col;
      PH_REV_JOIN:   v = abv;
      default:       v = 0;
    endcase

    not_last = strip_row + 1 < l;
    case (strip_phase)
      PH_PAIR_CUR: strip_phase = PH_PAIR_ABOVE;
      PH_PAIR_ABOVE: begin
        if (strip_col + 1 < w) begin
          strip_phase = PH_PAIR_CUR;
          strip_col++;
        end else if (flag_right || not_last) begin
          strip_phase = PH_JOIN;
          strip_col   = 0;
        end else begin
          done = end_row(w, l);
        end
      end
      PH_JOIN: begin
        // right stitch gives three indices, the plain join just one
        if (flag_right && strip_col < 2) strip_col++;
        else done = end_row(w, l);
      end
      PH_NB_LEAD: begin
        if (strip_col < 1) begin
          strip_col++;
        end else begin
          strip_phase = PH_REV_CUR;
          strip_col   = 32'(w - 1);
        end
      end
      PH_REV_CUR: strip_phase = PH_REV_ABOVE;
      PH_REV_ABOVE: begin
        if (strip_col > 0) begin
          strip_phase = PH_REV_CUR;
          strip_col--;
        end else if (not_last) begin
          strip_phase = PH_REV_JOIN;
        end else begin
          done = end_row(w, l);
        end
      end
      default: done = end_row(w, l);
    endcase

    res.vertex_index  = v[INDEX_W-1:0];
    res.last_in_group = done;
    return 1'b1;
  endfunction

  // ---------------------------------------------------------------------
  // request side
  // ---------------------------------------------------------------------

  // sends one request, with a random lead-in gap; in_push stays high afterwards
  task automatic push_request(input logic kind, input logic above, input logic right);
    gsig_in_t  req;
    gsig_out_t res;
    req.kind            = kind;
    req.neighbour_above = above;
    req.neighbour_right = right;
    while ($urandom_range(99) < send_idle_pct) begin
      in_push <= 1'b0;
      @(posedge clk);
    end
    in_push <= 1'b1;
    in_item <= req;
    do @(posedge clk); while (in_full);
    // emits with no group running are ignored and not counted
    if (kind == KIND_START || strip_active) items_sent++;
    if (next_strip_index(req, res)) expected_indices = {expected_indices, res};
  endtask

  // hold off until every owed index is back, then let the pipeline settle
  task automatic drain_results();
    in_push <= 1'b0;
    while (expected_indices.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // writes all three registers back to back, optionally also the unused index
  task automatic set_registers(input logic [CFG_DATA_W-1:0] w, input logic [CFG_DATA_W-1:0] l,
                               input logic [CFG_DATA_W-1:0] c, input bit poke_unused);
    logic [CFG_IDX_W-1:0]  reg_ids [4];
    logic [CFG_DATA_W-1:0] reg_vals [4];
    int                    last;
    reg_ids  = '{CFG_GRID_WIDTH, CFG_GRID_LENGTH, CFG_PATCHES_ACROSS, CFG_UNUSED_INDEX};
    reg_vals = '{w, l, c, CFG_DATA_W'($urandom_range(0, 511))};
    last     = poke_unused ? 3 : 2;
    for (int i = 0; i <= last; i++) begin
      cfg_valid <= 1'b1;
      cfg_index <= reg_ids[i];
      cfg_data  <= reg_vals[i];
      do @(posedge clk); while (!cfg_ready);
      case (reg_ids[i])
        CFG_GRID_WIDTH:     width_reg  = reg_vals[i];
        CFG_GRID_LENGTH:    length_reg = reg_vals[i];
        CFG_PATCHES_ACROSS: across_reg = reg_vals[i][ACROSS_W-1:0];
        default: ;
      endcase
    end
    cfg_valid <= 1'b0;
  endtask

  // mostly tiny patches, sometimes an out-of-range or extreme size
  function automatic logic [CFG_DATA_W-1:0] random_dim();
    if ($urandom_range(4) != 0) return CFG_DATA_W'($urandom_range(2, 5));
    case ($urandom_range(4))
      0:       return CFG_DATA_W'(0);
      1:       return CFG_DATA_W'(1);
      2:       return CFG_DATA_W'(256);
      3:       return CFG_DATA_W'(511);
      default: return CFG_DATA_W'($urandom_range(0, 511));
    endcase
  endfunction

  // ---------------------------------------------------------------------
  // result side: random pop stalls and in-order compare
  // ---------------------------------------------------------------------
  always @(posedge clk) begin : check_results
    gsig_out_t want;
    out_pop <= ($urandom_range(99) >= recv_idle_pct);
    if (rst_n && out_pop && !out_empty) begin
      if (expected_indices.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= PRINT_LIMIT)
          $display("%0t: unexpected index, expected none, got %0d last %0b",
                   $time, out_item.vertex_index, out_item.last_in_group);
      end else begin
        want = expected_indices.pop_front();
        if (out_item.vertex_index !== want.vertex_index) begin
          mismatch_count++;
          if (mismatch_count <= PRINT_LIMIT)
            $display("%0t: vertex_index mismatch, expected %0d, got %0d",
                     $time, want.vertex_index, out_item.vertex_index);
        end
        if (out_item.last_in_group !== want.last_in_group) begin
          mismatch_count++;
          if (mismatch_count <= PRINT_LIMIT)
            $display("%0t: last_in_group mismatch, expected %0b, got %0b",
                     $time, want.last_in_group, out_item.last_in_group);
        end
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > LIMIT_CYCLES) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  // ---------------------------------------------------------------------
  // tests
  // ---------------------------------------------------------------------

  // emit before any start gives nothing; then a few indices at reset sizes
  task automatic test_reset_state();
    push_request(KIND_EMIT, 1'b1, 1'b1);
    push_request(KIND_START, 1'b0, 1'b0);
    repeat (3) push_request(KIND_EMIT, 1'b0, 1'b0);
  endtask

  // width below range, length above range, zero patches; unused index ignored
  task automatic test_clamped_registers();
    drain_results();
    set_registers(CFG_DATA_W'(0), CFG_DATA_W'(511), CFG_DATA_W'(0), 1'b1);
    push_request(KIND_START, 1'b1, 1'b1);
    // far enough to reach the right-neighbour stitch, which shows the clamped length
    repeat (6) push_request(KIND_EMIT, 1'b0, 1'b1);
  endtask

  // smallest patch with both neighbours and the widest patch count (masked to 7 bits);
  // the start drops the group left running by the previous test
  task automatic test_top_row_stitch();
    drain_results();
    set_registers(CFG_DATA_W'(2), CFG_DATA_W'(2), CFG_DATA_W'(511), 1'b0);
    push_request(KIND_START, 1'b1, 1'b1);
    while (strip_active)
      push_request(KIND_EMIT, 1'($urandom_range(1)), 1'($urandom_range(1)));
  endtask

  // whole groups with random flags over random sizes, plus cut-off groups,
  // stray emits and size changes in the middle of a group
  task automatic test_random_strips(input int sender_pct, input int receiver_pct);
    int  sent_at_start;
    int  emit_cap;
    int  emitted;
    bit  big;
    send_idle_pct = sender_pct;
    recv_idle_pct = receiver_pct;
    sent_at_start = items_sent;
    while (items_sent - sent_at_start < RANDOM_ITEMS) begin
      drain_results();
      set_registers(random_dim(), random_dim(), CFG_DATA_W'($urandom_range(0, 511)),
                    $urandom_range(7) == 0);
      // carry on a group that was left running, now with the new sizes
      if ($urandom_range(1) == 1)
        repeat ($urandom_range(1, 8))
          push_request(KIND_EMIT, 1'($urandom_range(1)), 1'($urandom_range(1)));
      big = clamp_reg(width_reg, 2, MAX_WIDTH) > 6 || clamp_reg(length_reg, 2, MAX_LENGTH) > 6;
      repeat ($urandom_range(1, 4)) begin
        if ($urandom_range(9) == 0)
          push_request(KIND_EMIT, 1'($urandom_range(1)), 1'($urandom_range(1)));
        push_request(KIND_START, 1'($urandom_range(1)), 1'($urandom_range(1)));
        if (big) emit_cap = $urandom_range(4, 40);
        else if ($urandom_range(4) == 0) emit_cap = $urandom_range(0, 12);
        else emit_cap = 1000;
        emitted = 0;
        while (strip_active && emitted < emit_cap) begin
          push_request(KIND_EMIT, 1'($urandom_range(1)), 1'($urandom_range(1)));
          emitted++;
        end
        // more emits: past the end of a group they give nothing, in a cut-off group they continue it
        if ($urandom_range(3) == 0)
          repeat ($urandom_range(1, 2))
            push_request(KIND_EMIT, 1'($urandom_range(1)), 1'($urandom_range(1)));
      end
    end
  endtask

  initial begin
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    test_reset_state();
    test_clamped_registers();
    test_top_row_stitch();

    // sender idles 29%, receiver 45%; then swapped; then no idling
    test_random_strips(29, 45);
    test_random_strips(45, 29);
    test_random_strips(0, 0);

    drain_results();
    if (mismatch_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
